// ----- rtl/three_d_dominance_count_histogram_macros.svh -----
// assertion helpers for the dominance count histogram
`ifndef THREE_D_DOMINANCE_COUNT_HISTOGRAM_MACROS_SVH
`define THREE_D_DOMINANCE_COUNT_HISTOGRAM_MACROS_SVH

// implication checked in the cycle after the antecedent
`define TDDH_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

// invariant checked at every edge
`define TDDH_ALWAYS(lbl, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (con)) else $error(msg);

`endif

// ----- rtl/tddh_pkg.sv -----
package tddh_pkg;
  localparam int MAX_POINTS  = 1024;
  localparam int COORD_WIDTH = 18;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int PT_W        = 3 * COORD_WIDTH;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_COMPUTE = 2'd1;
  localparam cmd_t CMD_READ    = 2'd2;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef struct packed {
    coord_t c;
    coord_t b;
    coord_t a;
  } point_t;
endpackage

// ----- rtl/three_d_dominance_count_histogram.sv -----
// Three-dimensional dominance count histogram.
// Input channel s_*: one beat is a command in s_tuser and its operands in s_tdata.
// Load stores a point as its beat is taken and gives no result; a load into a full
// store is dropped and sets a sticky flag. Compute counts, for every stored
// point, the other points that are less than or equal in all three coordinates,
// and bins those counts; it returns one result beat when done. Read returns one
// histogram bin through the S_READ state and the output register.
// Loads can be taken back to back; no command is taken while a read or compute
// runs. Compute for T stored points makes a clearing pass over T histogram bins,
// then per point one read of that point, one pass over the single read port of
// the point memory, and a read-modify-write of the histogram memory.
// Output channel m_*: one registered result beat; a new command is taken only
// when that register is empty or draining, so a stalled receiver holds the block.
// Reset empties the point store, clears the drop flag and makes every bin read 0.
module three_d_dominance_count_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_a, coord_b, coord_c, bin_index
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // bin_count, total_points, dropped, zero pad
);
  `include "three_d_dominance_count_histogram_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CLEAR, S_LOAD_I, S_SCAN, S_HIST_RD, S_HIST_WR
  } state_t;

  localparam int AW = tddh_pkg::ADDR_W;
  localparam int CW = tddh_pkg::CNT_W;

  state_t state;
  logic [CW-1:0] total, hist_total, i_idx, j_next, j_data, cnt;
  logic          overflow, data_v;
  tddh_pkg::point_t pi;

  tddh_pkg::point_t pt_mem [tddh_pkg::MAX_POINTS];
  logic [CW-1:0]    hist_mem [tddh_pkg::MAX_POINTS];
  tddh_pkg::point_t pt_q;
  logic [CW-1:0]    hist_q;
  logic [AW-1:0]    pt_raddr, hist_raddr, hist_waddr;
  logic [CW-1:0]    hist_wdata;
  logic             hist_we, pt_we;

  tddh_pkg::cmd_t   cmd;
  tddh_pkg::point_t in_pt;
  logic [9:0]       bin;
  logic             take, below, out_set;

  assign cmd      = tddh_pkg::cmd_t'(s_tuser);
  assign in_pt.a  = s_tdata[17:0];
  assign in_pt.b  = s_tdata[35:18];
  assign in_pt.c  = s_tdata[53:36];
  assign bin      = s_tdata[63:54];
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;
  assign pt_we    = take && (cmd == tddh_pkg::CMD_LOAD) &&
                    (total < CW'(tddh_pkg::MAX_POINTS));
  assign below    = (pt_q.a <= pi.a) && (pt_q.b <= pi.b) && (pt_q.c <= pi.c);
  assign out_set  = (take && (cmd == tddh_pkg::CMD_COMPUTE) && (total == '0)) ||
                    (state == S_READ) ||
                    ((state == S_HIST_WR) && (i_idx == total - CW'(1)));

  always_comb begin
    pt_raddr   = j_next[AW-1:0];
    hist_raddr = cnt[AW-1:0];
    hist_we    = 1'b0;
    hist_waddr = i_idx[AW-1:0];
    hist_wdata = '0;
    if (state == S_IDLE) begin
      pt_raddr   = i_idx[AW-1:0];
      hist_raddr = AW'(bin);
    end else if (state == S_LOAD_I) begin
      pt_raddr = i_idx[AW-1:0];
    end else if (state == S_CLEAR) begin
      hist_we = 1'b1;
    end else if (state == S_HIST_WR) begin
      hist_we    = 1'b1;
      hist_waddr = cnt[AW-1:0];
      hist_wdata = hist_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[total[AW-1:0]] <= in_pt;
    pt_q <= pt_mem[pt_raddr];
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      hist_total <= '0;
      overflow   <= 1'b0;
      m_tvalid   <= 1'b0;
      i_idx      <= '0;
      j_next     <= '0;
      j_data     <= '0;
      data_v     <= 1'b0;
      cnt        <= '0;
    end else begin
      m_tvalid <= out_set || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          i_idx <= '0;
          if (take) begin
            unique case (cmd)
              tddh_pkg::CMD_LOAD: begin
                if (pt_we) total <= total + CW'(1);
                else overflow <= 1'b1;
              end
              tddh_pkg::CMD_COMPUTE: begin
                hist_total <= total;
                state      <= (total == '0) ? S_IDLE : S_CLEAR;
                if (total == '0) begin
                  m_tdata  <= {1'b0, overflow, 11'(total), 11'd0};
                end
              end
              tddh_pkg::CMD_READ: begin
                j_data <= CW'(bin);
                state  <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          m_tdata  <= {1'b0, overflow, 11'(total),
                       (j_data < hist_total) ? 11'(hist_q) : 11'd0};
          state    <= S_IDLE;
        end
        S_CLEAR: begin
          if (i_idx == total - CW'(1)) begin
            i_idx <= '0;
            state <= S_LOAD_I;
          end else begin
            i_idx <= i_idx + CW'(1);
          end
        end
        S_LOAD_I: begin
          j_next <= '0;
          data_v <= 1'b0;
          cnt    <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (j_next == '0 && !data_v) pi <= pt_q;
          if (data_v && j_data != i_idx && below) cnt <= cnt + CW'(1);
          if (j_next < total) begin
            data_v <= 1'b1;
            j_data <= j_next;
            j_next <= j_next + CW'(1);
          end else begin
            data_v <= 1'b0;
            if (!data_v) state <= S_HIST_RD;
          end
        end
        S_HIST_RD: state <= S_HIST_WR;
        S_HIST_WR: begin
          if (i_idx == total - CW'(1)) begin
            m_tdata  <= {1'b0, overflow, 11'(total), 11'd0};
            state    <= S_IDLE;
          end else begin
            i_idx <= i_idx + CW'(1);
            state <= S_LOAD_I;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TDDH_ALWAYS(a_total_cap, total <= CW'(tddh_pkg::MAX_POINTS), "point count above capacity")
  `TDDH_ALWAYS(a_hist_total, hist_total <= total, "histogram span beyond point count")
  `TDDH_ALWAYS(a_ready_idle, !s_tready || state == S_IDLE, "ready outside idle")
  `TDDH_NEXT(a_read_result, state == S_READ, m_tvalid, "read gave no result")
endmodule
